// ===== hw/rtl/stpq_pkg.sv =====
package stpq_pkg;

   // Sizing of the queue
   localparam int CAPACITY    = 64;
   localparam int FIELD_WIDTH = 32;
   localparam int POS_W       = 6;
   localparam int COUNT_W     = $clog2(CAPACITY + 1);
   localparam int CMP_W       = (POS_W > COUNT_W) ? POS_W : COUNT_W;

   // Operation codes carried on req_kind
   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // Status codes returned on rsp_status
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   // One stored entry
   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] key;
      logic signed [FIELD_WIDTH-1:0] payload_a;
      logic signed [FIELD_WIDTH-1:0] payload_b;
   } entry_type;

   // Broadcast from the top level to every cell
   typedef struct packed {
      logic               insert;
      logic               remove;
      logic [COUNT_W-1:0] count;
      entry_type          new_entry;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/stpq_cell.sv =====
module stpq_cell (
   input  logic                         clock,
   input  stpq_pkg::cell_ctrl_type      ctrl,
   input  logic [stpq_pkg::COUNT_W-1:0] cell_index,
   input  stpq_pkg::entry_type          left_entry,
   input  logic                         left_after,
   input  stpq_pkg::entry_type          right_entry,
   output stpq_pkg::entry_type          entry,
   output logic                         after
);

   stpq_pkg::entry_type entry_ff;
   stpq_pkg::entry_type entry_in;
   logic                occupied;

   // Entry is live below the count; it sorts after the new key when key >= new key
   assign occupied = cell_index < ctrl.count;
   assign after    = occupied && (entry_ff.key >= ctrl.new_entry.key);
   assign entry    = entry_ff;

   // Insert shifts the tail right by one, remove shifts everything left by one
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (left_after) begin
            entry_in = left_entry;
         end else if (after || (cell_index == ctrl.count)) begin
            entry_in = ctrl.new_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hw/rtl/sorted_tuple_priority_queue_unit.sv =====
// Sorted priority queue of (key, payload_a, payload_b) entries held in a row of cells,
// ascending by signed key, newest first among equal keys. One operation is taken per
// clock cycle: busy never rises, so start may be held high every cycle. The result of
// an operation appears on the rsp_ ports for one cycle, marked by rsp_valid, in the
// cycle after start; it must be captured then, as there is no way to hold it off.
// Insert and remove complete through a one-place shift along the
// cell row; a read selects the addressed cell through one wide multiplexer.
// Entry storage has no reset; reset clears the count and rsp_valid, and a clear operation clears only the count.
module sorted_tuple_priority_queue_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_kind,
   input  logic signed [stpq_pkg::FIELD_WIDTH-1:0] req_key,
   input  logic signed [stpq_pkg::FIELD_WIDTH-1:0] req_payload_a,
   input  logic signed [stpq_pkg::FIELD_WIDTH-1:0] req_payload_b,
   input  logic [stpq_pkg::POS_W-1:0]              req_position,
   output logic                                    rsp_valid,
   output logic [1:0]                              rsp_status,
   output logic [stpq_pkg::COUNT_W-1:0]            rsp_count,
   output logic signed [stpq_pkg::FIELD_WIDTH-1:0] rsp_out_key,
   output logic signed [stpq_pkg::FIELD_WIDTH-1:0] rsp_out_payload_a,
   output logic signed [stpq_pkg::FIELD_WIDTH-1:0] rsp_out_payload_b
);

   localparam int CAP = stpq_pkg::CAPACITY;

   logic [stpq_pkg::COUNT_W-1:0] count_ff;
   logic [stpq_pkg::COUNT_W-1:0] count_in;
   logic                         valid_ff;
   stpq_pkg::status_type         status_ff;
   stpq_pkg::status_type         status_in;
   stpq_pkg::entry_type          data_ff;
   stpq_pkg::entry_type          data_in;
   stpq_pkg::entry_type          read_entry;
   stpq_pkg::kind_type           kind;
   stpq_pkg::cell_ctrl_type      ctrl;
   stpq_pkg::entry_type          cell_entry [CAP];
   logic                         cell_after [CAP];
   logic                         full;
   logic                         empty;
   logic                         in_range;

   assign busy  = 1'b0;
   assign kind  = stpq_pkg::kind_type'(req_kind);
   assign full  = count_ff == stpq_pkg::COUNT_W'(CAP);
   assign empty = count_ff == '0;
   assign in_range = stpq_pkg::CMP_W'(req_position) < stpq_pkg::CMP_W'(count_ff);

   // Broadcast to the cells; shifts are gated by the full and empty checks
   always_comb begin
      ctrl.insert              = start && (kind == stpq_pkg::KIND_INSERT) && !full;
      ctrl.remove              = start && (kind == stpq_pkg::KIND_REMOVE) && !empty;
      ctrl.count               = count_ff;
      ctrl.new_entry.key       = req_key;
      ctrl.new_entry.payload_a = req_payload_a;
      ctrl.new_entry.payload_b = req_payload_b;
   end

   // Cell row
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      stpq_pkg::entry_type left_entry;
      stpq_pkg::entry_type right_entry;
      logic                left_after;

      if (i == 0) begin : g_head
         assign left_entry = ctrl.new_entry;
         assign left_after = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_after = cell_after[i-1];
      end

      if (i == CAP - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_link
         assign right_entry = cell_entry[i+1];
      end

      stpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .cell_index  (stpq_pkg::COUNT_W'(i)),
         .left_entry  (left_entry),
         .left_after  (left_after),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .after       (cell_after[i])
      );
   end

   // Read selection over the cell row
   always_comb begin
      read_entry = '0;
      for (int i = 0; i < CAP; i++) begin
         if (stpq_pkg::CMP_W'(req_position) == stpq_pkg::CMP_W'(i)) begin
            read_entry = cell_entry[i];
         end
      end
   end

   // Count update and result formation
   always_comb begin
      count_in  = count_ff;
      status_in = stpq_pkg::STATUS_OK;
      data_in   = '0;
      case (kind)
         stpq_pkg::KIND_INSERT: begin
            if (full) begin
               status_in = stpq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         stpq_pkg::KIND_REMOVE: begin
            if (empty) begin
               status_in = stpq_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               data_in  = cell_entry[0];
            end
         end
         stpq_pkg::KIND_READ: begin
            if (in_range) begin
               data_in = read_entry;
            end else begin
               status_in = stpq_pkg::STATUS_RANGE;
            end
         end
         stpq_pkg::KIND_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
         if (start) begin
            count_ff <= count_in;
         end
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (start) begin
         status_ff <= status_in;
         data_ff   <= data_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_count         = count_ff;
   assign rsp_out_key       = data_ff.key;
   assign rsp_out_payload_a = data_ff.payload_a;
   assign rsp_out_payload_b = data_ff.payload_b;

endmodule
